/* hw/rtl/bif_pkg.sv */
// ----------------------------------------------------------------------------
// bif_pkg
// Shared types and constants of the bilateral image filter: item opcodes,
// register indexes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bif_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_RANGE   = 2'd0,
    OP_LOAD_SPATIAL = 2'd1,
    OP_PIXEL        = 2'd2,
    OP_FLUSH        = 2'd3
  } op_e;

  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_COLOUR_MODE  = 2'd2;

  localparam int CFG_W   = 11;
  localparam int PIX_W   = 8;
  localparam int POS_W   = 10;
  localparam int TIDX_W  = 10;
  localparam int TWGT_W  = 16;
  localparam int RANGE_DEPTH = 768;
  localparam int RANGE_AW    = 10;

  localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_WALK,
    ST_TAP,
    ST_FLUSH,
    ST_DIV_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic ls_we;
    logic rg_we;
    logic sp_we;
    logic ctr_rd;
    logic tap_rd;
    logic div_load;
    logic div_step;
    logic out_load;
    logic colour;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

/* hw/rtl/bif_ram.sv */
// ----------------------------------------------------------------------------
// bif_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bif_ctrl.sv */
// ----------------------------------------------------------------------------
// bif_ctrl
// Controller of the bilateral filter: stream positions, configuration,
// border-reflecting window walk and sequencing of the datapath.
// ----------------------------------------------------------------------------
module bif_ctrl #(
  parameter int RADIUS     = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_valid_i,
  output logic                                        in_stall_o,
  input  bif_pkg::op_e                                op_i,
  input  logic                                        cfg_valid_i,
  input  logic [1:0]                                  cfg_index_i,
  input  logic [bif_pkg::CFG_W-1:0]                   cfg_data_i,
  output bif_pkg::dp_cmd_t                            cmd_o,
  input  bif_pkg::dp_stat_t                           stat_i,
  output logic [$clog2(2*RADIUS+1)-1:0]               wr_slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                wr_col_o,
  output logic [$clog2(2*RADIUS+1)-1:0]               rd_slot_o,
  output logic [$clog2(MAX_WIDTH)-1:0]                rd_col_o,
  output logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] sp_idx_o,
  output logic [bif_pkg::POS_W-1:0]                   out_row_o,
  output logic [bif_pkg::POS_W-1:0]                   out_col_o,
  output logic                                        out_last_o
);
  import bif_pkg::*;

  localparam int TAPS = 2 * RADIUS + 1;
  localparam int NT   = TAPS * TAPS;
  localparam int SLW  = $clog2(TAPS);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WE   = $clog2(MAX_WIDTH + 1);
  localparam int HE   = $clog2(MAX_HEIGHT + 1);
  localparam int SPW  = $clog2(NT);
  localparam int TCW  = $clog2(TAPS);
  localparam int LINW = WE + HE;
  localparam int CNTW = 4;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] width_q, width_d, height_q, height_d;
  logic             colour_q, colour_d;
  logic [HE-1:0]    in_row_q, in_row_d;
  logic [CW-1:0]    in_col_q, in_col_d;
  logic [SLW-1:0]   in_slot_q, in_slot_d;
  logic             draining_q, draining_d;
  logic [RW-1:0]    er_q, er_d;
  logic [CW-1:0]    ec_q, ec_d;
  logic [SLW-1:0]   eslot_q, eslot_d;
  logic [RW-1:0]    rpos_q, rpos_d;
  logic             rdir_q, rdir_d;
  logic [SLW-1:0]   rslot_q, rslot_d;
  logic [CW-1:0]    cpos_q, cpos_d;
  logic             cdir_q, cdir_d;
  logic [CW-1:0]    cstart_q, cstart_d;
  logic             cdirst_q, cdirst_d;
  logic [TCW-1:0]   tcol_q, tcol_d, trow_q, trow_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  logic [WE-1:0]    w_eff;
  logic [HE-1:0]    h_eff;
  logic [LINW-1:0]  lin, thr;
  logic             last;
  logic             accept;
  logic [RW-1:0]    rpos_n;
  logic             rdir_n;
  logic [SLW-1:0]   rslot_n;
  logic [CW-1:0]    cpos_n;
  logic             cdir_n;

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    return (s == SLW'(TAPS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLW-1:0] slot_dec(input logic [SLW-1:0] s);
    return (s == '0) ? SLW'(TAPS - 1) : s - 1'b1;
  endfunction

  always_comb begin
    if (width_q == '0) begin
      w_eff = WE'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WE'(MAX_WIDTH);
    end else begin
      w_eff = WE'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HE'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_eff = HE'(MAX_HEIGHT);
    end else begin
      h_eff = HE'(height_q);
    end
  end

  // One reflect-101 step of the row walk; the ring slot follows the row.
  // A direction bit of one means the position is decreasing.
  always_comb begin
    rpos_n  = rpos_q;
    rdir_n  = rdir_q;
    rslot_n = rslot_q;
    if (h_eff != HE'(1)) begin
      if (rdir_q) begin
        if (rpos_q == '0) begin
          rpos_n  = RW'(1);
          rdir_n  = 1'b0;
          rslot_n = slot_inc(rslot_q);
        end else begin
          rpos_n  = rpos_q - 1'b1;
          rslot_n = slot_dec(rslot_q);
        end
      end else begin
        if (HE'(rpos_q) == h_eff - 1'b1) begin
          rpos_n  = RW'(h_eff - HE'(2));
          rdir_n  = 1'b1;
          rslot_n = slot_dec(rslot_q);
        end else begin
          rpos_n  = rpos_q + 1'b1;
          rslot_n = slot_inc(rslot_q);
        end
      end
    end
  end

  always_comb begin
    cpos_n = cpos_q;
    cdir_n = cdir_q;
    if (w_eff != WE'(1)) begin
      if (cdir_q) begin
        if (cpos_q == '0) begin
          cpos_n = CW'(1);
          cdir_n = 1'b0;
        end else begin
          cpos_n = cpos_q - 1'b1;
        end
      end else begin
        if (WE'(cpos_q) == w_eff - 1'b1) begin
          cpos_n = CW'(w_eff - WE'(2));
          cdir_n = 1'b1;
        end else begin
          cpos_n = cpos_q + 1'b1;
        end
      end
    end
  end

  assign lin  = LINW'(in_row_q) * LINW'(w_eff) + LINW'(in_col_q);
  assign thr  = LINW'(RADIUS) * LINW'(w_eff) + LINW'(RADIUS);
  assign last = (HE'(er_q) == h_eff - 1'b1) && (WE'(ec_q) == w_eff - 1'b1);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    width_d    = width_q;
    height_d   = height_q;
    colour_d   = colour_q;
    in_row_d   = in_row_q;
    in_col_d   = in_col_q;
    in_slot_d  = in_slot_q;
    draining_d = draining_q;
    er_d       = er_q;
    ec_d       = ec_q;
    eslot_d    = eslot_q;
    rpos_d     = rpos_q;
    rdir_d     = rdir_q;
    rslot_d    = rslot_q;
    cpos_d     = cpos_q;
    cdir_d     = cdir_q;
    cstart_d   = cstart_q;
    cdirst_d   = cdirst_q;
    tcol_d     = tcol_q;
    trow_d     = trow_q;
    sp_d       = sp_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.colour = colour_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_LOAD_RANGE:   cmd_o.rg_we = 1'b1;
            OP_LOAD_SPATIAL: cmd_o.sp_we = 1'b1;
            OP_PIXEL: begin
              if (!draining_q) begin
                cmd_o.ls_we = 1'b1;
                if (WE'(in_col_q) + WE'(1) >= w_eff) begin
                  in_col_d  = '0;
                  in_row_d  = in_row_q + 1'b1;
                  in_slot_d = slot_inc(in_slot_q);
                  if (in_row_q + HE'(1) >= h_eff) begin
                    draining_d = 1'b1;
                  end
                end else begin
                  in_col_d = in_col_q + 1'b1;
                end
                if (lin >= thr) begin
                  state_d = ST_CENTER;
                end
              end
            end
            OP_FLUSH: begin
              if (draining_q) begin
                state_d = ST_CENTER;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CENTER: begin
        cmd_o.ctr_rd = 1'b1;
        rpos_d  = er_q;
        rdir_d  = 1'b1;
        rslot_d = eslot_q;
        cpos_d  = ec_q;
        cdir_d  = 1'b1;
        cnt_d   = CNTW'(RADIUS);
        state_d = ST_WALK;
      end
      ST_WALK: begin
        // Walk back RADIUS steps to the window corner, then turn around.
        rpos_d  = rpos_n;
        rdir_d  = rdir_n;
        rslot_d = rslot_n;
        cpos_d  = cpos_n;
        cdir_d  = cdir_n;
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          rdir_d   = !rdir_n;
          cdir_d   = !cdir_n;
          cstart_d = cpos_n;
          cdirst_d = !cdir_n;
          tcol_d   = '0;
          trow_d   = '0;
          sp_d     = '0;
          state_d  = ST_TAP;
        end
      end
      ST_TAP: begin
        cmd_o.tap_rd = 1'b1;
        sp_d = sp_q + 1'b1;
        if (tcol_q == TCW'(TAPS - 1)) begin
          tcol_d  = '0;
          cpos_d  = cstart_q;
          cdir_d  = cdirst_q;
          rpos_d  = rpos_n;
          rdir_d  = rdir_n;
          rslot_d = rslot_n;
          if (trow_q == TCW'(TAPS - 1)) begin
            cnt_d   = CNTW'(3);
            state_d = ST_FLUSH;
          end else begin
            trow_d = trow_q + 1'b1;
          end
        end else begin
          tcol_d = tcol_q + 1'b1;
          cpos_d = cpos_n;
          cdir_d = cdir_n;
        end
      end
      ST_FLUSH: begin
        // Let the last taps run through the accumulate pipeline.
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          state_d = ST_DIV_LOAD;
        end
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cnt_d   = CNTW'(8);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
          if (last) begin
            in_row_d   = '0;
            in_col_d   = '0;
            in_slot_d  = '0;
            er_d       = '0;
            ec_d       = '0;
            eslot_d    = '0;
            draining_d = 1'b0;
          end else if (WE'(ec_q) + WE'(1) >= w_eff) begin
            ec_d    = '0;
            er_d    = er_q + 1'b1;
            eslot_d = slot_inc(eslot_q);
          end else begin
            ec_d = ec_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // A register write restarts the stream.
    if (cfg_valid_i && (cfg_index_i == CFG_IMAGE_WIDTH || cfg_index_i == CFG_IMAGE_HEIGHT ||
                        cfg_index_i == CFG_COLOUR_MODE)) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_d  = cfg_data_i;
        CFG_IMAGE_HEIGHT: height_d = cfg_data_i;
        default:          colour_d = cfg_data_i[0];
      endcase
      in_row_d   = '0;
      in_col_d   = '0;
      in_slot_d  = '0;
      er_d       = '0;
      ec_d       = '0;
      eslot_d    = '0;
      draining_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      width_q    <= RESET_WIDTH;
      height_q   <= RESET_HEIGHT;
      colour_q   <= 1'b1;
      in_row_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      draining_q <= 1'b0;
      er_q       <= '0;
      ec_q       <= '0;
      eslot_q    <= '0;
      rpos_q     <= '0;
      rdir_q     <= 1'b0;
      rslot_q    <= '0;
      cpos_q     <= '0;
      cdir_q     <= 1'b0;
      cstart_q   <= '0;
      cdirst_q   <= 1'b0;
      tcol_q     <= '0;
      trow_q     <= '0;
      sp_q       <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      width_q    <= width_d;
      height_q   <= height_d;
      colour_q   <= colour_d;
      in_row_q   <= in_row_d;
      in_col_q   <= in_col_d;
      in_slot_q  <= in_slot_d;
      draining_q <= draining_d;
      er_q       <= er_d;
      ec_q       <= ec_d;
      eslot_q    <= eslot_d;
      rpos_q     <= rpos_d;
      rdir_q     <= rdir_d;
      rslot_q    <= rslot_d;
      cpos_q     <= cpos_d;
      cdir_q     <= cdir_d;
      cstart_q   <= cstart_d;
      cdirst_q   <= cdirst_d;
      tcol_q     <= tcol_d;
      trow_q     <= trow_d;
      sp_q       <= sp_d;
      cnt_q      <= cnt_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign wr_slot_o  = in_slot_q;
  assign wr_col_o   = in_col_q;
  assign rd_slot_o  = (state_q == ST_CENTER) ? eslot_q : rslot_q;
  assign rd_col_o   = (state_q == ST_CENTER) ? ec_q : cpos_q;
  assign sp_idx_o   = sp_q;
  assign out_row_o  = POS_W'(er_q);
  assign out_col_o  = POS_W'(ec_q);
  assign out_last_o = last;

endmodule

/* hw/rtl/bif_datapath.sv */
// ----------------------------------------------------------------------------
// bif_datapath
// Datapath of the bilateral filter: line store and weight tables, the
// per-tap weight and accumulate pipeline, a restoring divider and the
// output register.
// ----------------------------------------------------------------------------
module bif_datapath #(
  parameter int RADIUS      = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  bif_pkg::dp_cmd_t                            cmd_i,
  output bif_pkg::dp_stat_t                           stat_o,
  input  logic [$clog2(2*RADIUS+1)-1:0]               wr_slot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                wr_col_i,
  input  logic [$clog2(2*RADIUS+1)-1:0]               rd_slot_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]                rd_col_i,
  input  logic [$clog2((2*RADIUS+1)*(2*RADIUS+1))-1:0] sp_idx_i,
  input  logic [bif_pkg::POS_W-1:0]                   out_row_i,
  input  logic [bif_pkg::POS_W-1:0]                   out_col_i,
  input  logic                                        out_last_i,
  input  logic [bif_pkg::TIDX_W-1:0]                  table_index_i,
  input  logic [bif_pkg::TWGT_W-1:0]                  table_weight_i,
  input  logic [bif_pkg::PIX_W-1:0]                   pix_b_i,
  input  logic [bif_pkg::PIX_W-1:0]                   pix_g_i,
  input  logic [bif_pkg::PIX_W-1:0]                   pix_r_i,
  output logic                                        out_valid_o,
  input  logic                                        out_stall_i,
  output logic [bif_pkg::PIX_W-1:0]                   out_b_o,
  output logic [bif_pkg::PIX_W-1:0]                   out_g_o,
  output logic [bif_pkg::PIX_W-1:0]                   out_r_o,
  output logic [bif_pkg::POS_W-1:0]                   out_row_o,
  output logic [bif_pkg::POS_W-1:0]                   out_col_o,
  output logic                                        frame_last_o
);
  import bif_pkg::*;

  localparam int TAPS = 2 * RADIUS + 1;
  localparam int NT   = TAPS * TAPS;
  localparam int SPW  = $clog2(NT);
  localparam int LSD  = TAPS * MAX_WIDTH;
  localparam int LAW  = $clog2(LSD);
  localparam int WW   = (WEIGHT_BITS < TWGT_W) ? WEIGHT_BITS : TWGT_W;
  localparam int PW   = 2 * WW;
  localparam int WSW  = PW + $clog2(NT);
  localparam int SUMW = WSW + PIX_W;
  localparam int PXW  = 3 * PIX_W;

  logic [LAW-1:0]      ls_waddr, ls_raddr;
  logic [PXW-1:0]      ls_wdata, ls_rdata;
  logic [WW-1:0]       sp_rdata, rg_rdata;
  logic                rg_we, sp_we;
  logic [RANGE_AW-1:0] rng_idx;

  logic             v1_q, c1_q, v2_q, v3_q;
  logic [PXW-1:0]   center_q, pix2_q, pix3_q;
  logic [WW-1:0]    sp2_q;
  logic [PW-1:0]    wt_q;
  logic [WSW-1:0]   wsum_q;
  logic [SUMW-1:0]  sum_q [3];
  logic [SUMW-1:0]  rem_q [3];
  logic [SUMW-1:0]  den_sh_q;
  logic [WSW-1:0]   den_q;
  logic [PIX_W-1:0] quo_q [3];
  logic [PIX_W-1:0] res [3];

  logic             out_valid_q;
  logic [PIX_W-1:0] out_b_q, out_g_q, out_r_q;
  logic [POS_W-1:0] out_row_q, out_col_q;
  logic             out_last_q;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign ls_waddr = LAW'(wr_slot_i) * LAW'(MAX_WIDTH) + LAW'(wr_col_i);
  assign ls_raddr = LAW'(rd_slot_i) * LAW'(MAX_WIDTH) + LAW'(rd_col_i);
  assign ls_wdata = {pix_r_i, pix_g_i, pix_b_i};
  assign rg_we    = cmd_i.rg_we && (32'(table_index_i) < RANGE_DEPTH);
  assign sp_we    = cmd_i.sp_we && (32'(table_index_i) < NT);

  bif_ram #(.WIDTH(PXW), .DEPTH(LSD)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ls_we),
    .waddr_i (ls_waddr),
    .wdata_i (ls_wdata),
    .re_i    (cmd_i.ctr_rd || cmd_i.tap_rd),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  bif_ram #(.WIDTH(WW), .DEPTH(NT)) u_spatial_ram (
    .clk_i   (clk_i),
    .we_i    (sp_we),
    .waddr_i (SPW'(table_index_i)),
    .wdata_i (table_weight_i[WW-1:0]),
    .re_i    (cmd_i.tap_rd),
    .raddr_i (sp_idx_i),
    .rdata_o (sp_rdata)
  );

  bif_ram #(.WIDTH(WW), .DEPTH(RANGE_DEPTH)) u_range_ram (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (RANGE_AW'(table_index_i)),
    .wdata_i (table_weight_i[WW-1:0]),
    .re_i    (v1_q),
    .raddr_i (rng_idx),
    .rdata_o (rg_rdata)
  );

  // Range table index: distance to the center, summed over channels in colour.
  always_comb begin
    rng_idx = RANGE_AW'(abs_diff(ls_rdata[7:0], center_q[7:0]));
    if (cmd_i.colour) begin
      rng_idx = rng_idx + RANGE_AW'(abs_diff(ls_rdata[15:8], center_q[15:8]))
                        + RANGE_AW'(abs_diff(ls_rdata[23:16], center_q[23:16]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      c1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tap_rd;
      c1_q <= cmd_i.ctr_rd;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c1_q) begin
      center_q <= ls_rdata;
    end
    if (v1_q) begin
      pix2_q <= ls_rdata;
      sp2_q  <= sp_rdata;
    end
    if (v2_q) begin
      wt_q   <= sp2_q * rg_rdata;
      pix3_q <= pix2_q;
    end
    if (cmd_i.ctr_rd) begin
      wsum_q <= '0;
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= '0;
      end
    end else if (v3_q) begin
      wsum_q <= wsum_q + WSW'(wt_q);
      for (int ch = 0; ch < 3; ch++) begin
        sum_q[ch] <= sum_q[ch] + SUMW'(wt_q * pix3_q[ch*PIX_W +: PIX_W]);
      end
    end
    // Restoring division, one quotient bit per step, most significant first.
    if (cmd_i.div_load) begin
      den_q    <= wsum_q;
      den_sh_q <= SUMW'(wsum_q) << (PIX_W - 1);
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch] <= sum_q[ch];
        quo_q[ch] <= '0;
      end
    end else if (cmd_i.div_step) begin
      den_sh_q <= den_sh_q >> 1;
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_q[ch] >= den_sh_q) begin
          rem_q[ch] <= rem_q[ch] - den_sh_q;
          quo_q[ch] <= {quo_q[ch][PIX_W-2:0], 1'b1};
        end else begin
          quo_q[ch] <= {quo_q[ch][PIX_W-2:0], 1'b0};
        end
      end
    end
    if (cmd_i.out_load) begin
      out_b_q    <= res[0];
      out_g_q    <= cmd_i.colour ? res[1] : '0;
      out_r_q    <= cmd_i.colour ? res[2] : '0;
      out_row_q  <= out_row_i;
      out_col_q  <= out_col_i;
      out_last_q <= out_last_i;
    end
  end

  // Round half up; a zero weight sum passes the center pixel through.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (den_q == '0) begin
        res[ch] = center_q[ch*PIX_W +: PIX_W];
      end else if ({rem_q[ch][WSW-1:0], 1'b0} >= {1'b0, den_q} && quo_q[ch] != '1) begin
        res[ch] = quo_q[ch] + 1'b1;
      end else begin
        res[ch] = quo_q[ch];
      end
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign out_b_o      = out_b_q;
  assign out_g_o      = out_g_q;
  assign out_r_o      = out_r_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = out_last_q;

endmodule

/* hw/rtl/bilateral_image_filter_core.sv */
// ----------------------------------------------------------------------------
// bilateral_image_filter_core
// Streaming bilateral filter with reflect-101 borders, gray or colour.
// ----------------------------------------------------------------------------
// Input words carry an opcode: a range or spatial weight load, a pixel in
// raster order, or a flush tick. The input is stalled while a pixel is
// being filtered. A pixel emits the output RADIUS rows and RADIUS columns
// behind it; after the last pixel of a frame, each flush tick emits one of
// the pending outputs. Filtering one output reads one window tap per cycle
// through the line store read port, then runs a four-stage weight and
// accumulate pipeline and an eight-step restoring divider.
// Results sit in an output register; when the receiver stalls, the word
// holds and the block waits for the register to free before the next load.
// Register writes go through a separate valid/ready port, always ready, and
// restart the stream. Reset clears positions and sets the registers to 640
// by 480, colour; the line store and weight tables are not cleared and must
// be loaded before use.
// ----------------------------------------------------------------------------
module bilateral_image_filter_core #(
  parameter int RADIUS      = 3,
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [bif_pkg::TIDX_W-1:0]    table_index_i,
  input  logic [bif_pkg::TWGT_W-1:0]    table_weight_i,
  input  logic [bif_pkg::PIX_W-1:0]     pix_b_i,
  input  logic [bif_pkg::PIX_W-1:0]     pix_g_i,
  input  logic [bif_pkg::PIX_W-1:0]     pix_r_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bif_pkg::PIX_W-1:0]     out_b_o,
  output logic [bif_pkg::PIX_W-1:0]     out_g_o,
  output logic [bif_pkg::PIX_W-1:0]     out_r_o,
  output logic [bif_pkg::POS_W-1:0]     out_row_o,
  output logic [bif_pkg::POS_W-1:0]     out_col_o,
  output logic                          frame_last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [bif_pkg::CFG_W-1:0]     cfg_data_i
);
  import bif_pkg::*;

  localparam int TAPS = 2 * RADIUS + 1;

  dp_cmd_t                          cmd;
  dp_stat_t                         stat;
  logic [$clog2(TAPS)-1:0]          wr_slot, rd_slot;
  logic [$clog2(MAX_WIDTH)-1:0]     wr_col, rd_col;
  logic [$clog2(TAPS*TAPS)-1:0]     sp_idx;
  logic [POS_W-1:0]                 emit_row, emit_col;
  logic                             emit_last;

  assign cfg_ready_o = 1'b1;

  bif_ctrl #(
    .RADIUS     (RADIUS),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_e'(op_i)),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .stat_i      (stat),
    .wr_slot_o   (wr_slot),
    .wr_col_o    (wr_col),
    .rd_slot_o   (rd_slot),
    .rd_col_o    (rd_col),
    .sp_idx_o    (sp_idx),
    .out_row_o   (emit_row),
    .out_col_o   (emit_col),
    .out_last_o  (emit_last)
  );

  bif_datapath #(
    .RADIUS      (RADIUS),
    .MAX_WIDTH   (MAX_WIDTH),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .wr_slot_i      (wr_slot),
    .wr_col_i       (wr_col),
    .rd_slot_i      (rd_slot),
    .rd_col_i       (rd_col),
    .sp_idx_i       (sp_idx),
    .out_row_i      (emit_row),
    .out_col_i      (emit_col),
    .out_last_i     (emit_last),
    .table_index_i  (table_index_i),
    .table_weight_i (table_weight_i),
    .pix_b_i        (pix_b_i),
    .pix_g_i        (pix_g_i),
    .pix_r_i        (pix_r_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_b_o        (out_b_o),
    .out_g_o        (out_g_o),
    .out_r_o        (out_r_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .frame_last_o   (frame_last_o)
  );

endmodule
